@@ rtl/core/hagm_pkg.sv @@
// ----------------------------------------------------------------------------
// hagm_pkg
// Shared constants, types and helpers for the horizontal alpha gradient block.
// ----------------------------------------------------------------------------
package hagm_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_STOPS  = 16;
  localparam int WIDTH_W    = 13;   // image_width register / column counters
  localparam int COUNT_W    = 5;    // stop_count register
  localparam int STOP_IDX_W = 4;    // index of one stop
  localparam int ALPHA_W    = 8;
  localparam int ACC_W      = 17;   // gradient accumulator and step, signed
  localparam int DATA_W     = 64;   // APB data
  localparam int ADDR_W     = 5;    // APB byte address
  localparam int ROW_W      = 1;    // stop memory row address
  localparam int LANE_W     = 3;    // byte lane within a stop row
  localparam int DVD_W      = 16;   // divider dividend / quotient
  localparam int DSR_W      = 13;   // divider divisor
  localparam int DIV_CNT_W  = 4;    // divider iteration counter

  localparam logic [ALPHA_W-1:0] FULL_ALPHA = '1;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH,
    REG_STOP_COUNT,
    REG_STOPS_LOW,
    REG_STOPS_HIGH
  } reg_idx_t;

  typedef struct packed {
    logic              en;
    logic [ROW_W-1:0]  row;
    logic [DATA_W-1:0] data;
  } stop_wr_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] width;    // clipped to 1..MAX_WIDTH
    logic [COUNT_W-1:0] stops;    // clipped to MAX_STOPS and width
    logic               restart;  // any register write
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // Exact x / 255 for any 16-bit product of two bytes.
  function automatic logic [ALPHA_W-1:0] div255(input logic [2*ALPHA_W-1:0] x);
    logic [2*ALPHA_W:0] t;
    t = {1'b0, x} + {9'b0, x[2*ALPHA_W-1:ALPHA_W]} + 17'd1;
    return t[2*ALPHA_W-1:ALPHA_W];
  endfunction

endpackage

@@ rtl/core/hagm_stop_mem.sv @@
// ----------------------------------------------------------------------------
// hagm_stop_mem
// Stop table: two rows of eight stop bytes, one write port, two read ports
// with registered data. Rows not yet written read as zero.
// ----------------------------------------------------------------------------
module hagm_stop_mem (
  input  logic                                clk,
  input  logic                                rst,
  input  hagm_pkg::stop_wr_t                  wr,
  input  logic [hagm_pkg::ROW_W-1:0]          a_row,
  output logic [hagm_pkg::DATA_W-1:0]         a_data,
  input  logic [hagm_pkg::ROW_W-1:0]          b_row,
  output logic [hagm_pkg::DATA_W-1:0]         b_data
);

  localparam int ROWS = 2 ** hagm_pkg::ROW_W;

  logic [hagm_pkg::DATA_W-1:0] mem [ROWS];
  logic [ROWS-1:0]             row_valid;
  logic [hagm_pkg::DATA_W-1:0] a_raw;
  logic [hagm_pkg::DATA_W-1:0] b_raw;
  logic                        a_valid;
  logic                        b_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.row] <= wr.data;
    end
    a_raw <= mem[a_row];
    b_raw <= mem[b_row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
    end else begin
      if (wr.en) begin
        row_valid[wr.row] <= 1'b1;
      end
      a_valid <= row_valid[a_row];
      b_valid <= row_valid[b_row];
    end
  end

  assign a_data = a_valid ? a_raw : '0;
  assign b_data = b_valid ? b_raw : '0;

endmodule

@@ rtl/core/hagm_cfg.sv @@
// ----------------------------------------------------------------------------
// hagm_cfg
// APB register file: width and stop count in flops, stops in the stop memory.
// Produces the clipped width and stop count for the datapath.
// ----------------------------------------------------------------------------
module hagm_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hagm_pkg::ADDR_W-1:0]       paddr,
  input  logic [hagm_pkg::DATA_W-1:0]       pwdata,
  output logic [hagm_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  output hagm_pkg::stop_wr_t                stop_wr,
  output logic [hagm_pkg::ROW_W-1:0]        rd_row,
  input  logic [hagm_pkg::DATA_W-1:0]       rd_data,
  output hagm_pkg::cfg_t                    cfg
);

  logic [hagm_pkg::WIDTH_W-1:0] image_width;
  logic [hagm_pkg::COUNT_W-1:0] stop_count;
  hagm_pkg::reg_idx_t           idx;
  logic                         wr_en;
  logic [hagm_pkg::WIDTH_W-1:0] eff_w;
  logic [hagm_pkg::COUNT_W-1:0] eff_n;

  assign pready = 1'b1;
  assign idx    = hagm_pkg::reg_idx_t'(paddr[hagm_pkg::ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= hagm_pkg::WIDTH_W'(1);
      stop_count  <= hagm_pkg::COUNT_W'(1);
    end else if (wr_en) begin
      case (idx)
        hagm_pkg::REG_IMAGE_WIDTH: image_width <= pwdata[hagm_pkg::WIDTH_W-1:0];
        hagm_pkg::REG_STOP_COUNT:  stop_count  <= pwdata[hagm_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    stop_wr.en   = wr_en && (idx == hagm_pkg::REG_STOPS_LOW || idx == hagm_pkg::REG_STOPS_HIGH);
    stop_wr.row  = (idx == hagm_pkg::REG_STOPS_HIGH) ? 1'b1 : 1'b0;
    stop_wr.data = pwdata;
  end

  // Read the stop row every cycle; the access phase sees the setup-phase read.
  assign rd_row = (idx == hagm_pkg::REG_STOPS_HIGH) ? 1'b1 : 1'b0;

  always_comb begin
    case (idx)
      hagm_pkg::REG_IMAGE_WIDTH: prdata = hagm_pkg::DATA_W'(image_width);
      hagm_pkg::REG_STOP_COUNT:  prdata = hagm_pkg::DATA_W'(stop_count);
      default:                   prdata = rd_data;
    endcase
  end

  always_comb begin
    eff_w = image_width;
    if (image_width == '0) begin
      eff_w = hagm_pkg::WIDTH_W'(1);
    end else if (image_width > hagm_pkg::WIDTH_W'(hagm_pkg::MAX_WIDTH)) begin
      eff_w = hagm_pkg::WIDTH_W'(hagm_pkg::MAX_WIDTH);
    end
    eff_n = stop_count;
    if (stop_count > hagm_pkg::COUNT_W'(hagm_pkg::MAX_STOPS)) begin
      eff_n = hagm_pkg::COUNT_W'(hagm_pkg::MAX_STOPS);
    end
    if (hagm_pkg::WIDTH_W'(eff_n) > eff_w) begin
      eff_n = eff_w[hagm_pkg::COUNT_W-1:0];
    end
  end

  assign cfg.width   = eff_w;
  assign cfg.stops   = eff_n;
  assign cfg.restart = wr_en;

endmodule

@@ rtl/core/hagm_div.sv @@
// ----------------------------------------------------------------------------
// hagm_div
// Iterative restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module hagm_div (
  input  logic               clk,
  input  logic               rst,
  input  hagm_pkg::div_req_t req,
  output hagm_pkg::div_rsp_t rsp
);

  logic [hagm_pkg::DSR_W-1:0]     rem;
  logic [hagm_pkg::DVD_W-1:0]     quo;
  logic [hagm_pkg::DSR_W-1:0]     dsr;
  logic [hagm_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;
  logic [hagm_pkg::DSR_W:0]       trial;
  logic [hagm_pkg::DSR_W:0]       diff;
  logic                           fits;

  assign trial = {rem, quo[hagm_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[hagm_pkg::DSR_W-1:0] : trial[hagm_pkg::DSR_W-1:0];
      quo <= {quo[hagm_pkg::DVD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == hagm_pkg::DIV_CNT_W'(hagm_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

@@ rtl/core/horizontal_alpha_gradient_multiply.sv @@
// ----------------------------------------------------------------------------
// horizontal_alpha_gradient_multiply
// Scales each alpha byte of a row-ordered stream by a horizontal
// piecewise-linear gradient: alpha_out = alpha_in * g / 255, truncated.
//
//  channel  dir  handshake                 payload
//  s_*      in   s_tvalid / s_tready       s_tdata[7:0] = alpha_in
//  m_*      out  m_tvalid / m_tready       m_tdata[7:0] = alpha_out, m_tlast = row_end
//  apb      in   psel, penable, pready=1   paddr 8*i, 64-bit pwdata / prdata
//
// Inside a segment and past the last segment a word is accepted, then
// multiplied into the output register. The first word of each segment
// reads two stops from the stop memory and runs the step division; the
// first segment after a register write adds one more division for the
// segment width. Reset is synchronous. A held output register stalls only
// the final multiply step.
// ----------------------------------------------------------------------------
module horizontal_alpha_gradient_multiply (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] alpha_in
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,   // [7:0] alpha_out
  output logic                        m_tlast,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hagm_pkg::ADDR_W-1:0] paddr,
  input  logic [hagm_pkg::DATA_W-1:0] pwdata,
  output logic [hagm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIVW, S_RD0, S_RD1, S_RD2, S_DIVS
  } state_t;

  state_t                          state;
  hagm_pkg::cfg_t                  cfg;
  hagm_pkg::stop_wr_t              stop_wr;
  hagm_pkg::div_req_t              div_req;
  hagm_pkg::div_rsp_t              div_rsp;
  logic [hagm_pkg::ROW_W-1:0]      cfg_row;
  logic [hagm_pkg::DATA_W-1:0]     cfg_rd_data;
  logic [hagm_pkg::DATA_W-1:0]     a_data;
  logic [hagm_pkg::STOP_IDX_W-1:0] rd_idx;
  logic [hagm_pkg::LANE_W-1:0]     rd_lane;
  logic [hagm_pkg::ALPHA_W-1:0]    rd_byte;

  logic [hagm_pkg::ALPHA_W-1:0]    alpha;
  logic [hagm_pkg::ALPHA_W-1:0]    g;
  logic                            g_from_mem;
  logic                            last_flag;
  logic signed [hagm_pkg::ACC_W-1:0] acc;
  logic signed [hagm_pkg::ACC_W-1:0] step;
  logic signed [hagm_pkg::ACC_W-1:0] step_val;
  logic signed [hagm_pkg::ACC_W-1:0] acc_here;
  logic [hagm_pkg::WIDTH_W-1:0]    col;
  logic [hagm_pkg::STOP_IDX_W-1:0] seg;
  logic [hagm_pkg::WIDTH_W-1:0]    pos;
  logic [hagm_pkg::WIDTH_W-1:0]    w2;
  logic                            w2_ok;
  logic [hagm_pkg::ALPHA_W-1:0]    here;
  logic                            neg;
  logic                            out_valid;
  logic [hagm_pkg::ALPHA_W-1:0]    out_alpha;
  logic                            out_last;

  logic                            accept;
  logic                            out_free;
  logic [hagm_pkg::COUNT_W-1:0]    nm1;
  logic                            n_zero;
  logic                            in_seg;
  logic [hagm_pkg::WIDTH_W-1:0]    col_inc;
  logic                            is_last;
  logic [hagm_pkg::WIDTH_W-1:0]    pos_inc;
  logic                            seg_done;
  logic [hagm_pkg::ALPHA_W-1:0]    diff_mag;
  logic [hagm_pkg::ALPHA_W-1:0]    g_sel;
  logic [2*hagm_pkg::ALPHA_W-1:0]  product;

  hagm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .stop_wr (stop_wr),
    .rd_row  (cfg_row),
    .rd_data (cfg_rd_data),
    .cfg     (cfg)
  );

  hagm_stop_mem u_mem (
    .clk    (clk),
    .rst    (rst),
    .wr     (stop_wr),
    .a_row  (rd_idx[hagm_pkg::STOP_IDX_W-1]),
    .a_data (a_data),
    .b_row  (cfg_row),
    .b_data (cfg_rd_data)
  );

  hagm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  assign nm1      = cfg.stops - 1'b1;
  assign n_zero   = (cfg.stops == '0);
  assign in_seg   = !n_zero && ({1'b0, seg} < nm1);
  assign col_inc  = col + 1'b1;
  assign is_last  = (col_inc >= cfg.width);
  assign pos_inc  = pos + 1'b1;
  assign seg_done = (pos_inc >= w2);

  // Stop memory address: current and next stop at a segment start,
  // otherwise the last stop.
  always_comb begin
    case (state)
      S_RD0:   rd_idx = seg;
      S_RD1:   rd_idx = seg + 1'b1;
      default: rd_idx = nm1[hagm_pkg::STOP_IDX_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    rd_lane <= rd_idx[hagm_pkg::LANE_W-1:0];
  end

  assign rd_byte = a_data[rd_lane*hagm_pkg::ALPHA_W +: hagm_pkg::ALPHA_W];

  assign diff_mag = (rd_byte >= here) ? (rd_byte - here) : (here - rd_byte);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {diff_mag, 8'h00};
    div_req.divisor  = w2;
    if (state == S_IDLE) begin
      div_req.start    = accept && in_seg && (pos == '0) && !w2_ok;
      div_req.dividend = hagm_pkg::DVD_W'(cfg.width);
      div_req.divisor  = hagm_pkg::DSR_W'(nm1);
    end else if (state == S_RD2) begin
      div_req.start = 1'b1;
    end
  end

  assign step_val = neg ? -$signed({1'b0, div_rsp.quotient})
                        : $signed({1'b0, div_rsp.quotient});
  assign acc_here = $signed({1'b0, here, 8'h00});

  assign g_sel   = g_from_mem ? rd_byte : g;
  assign product = alpha * g_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      col       <= '0;
      seg       <= '0;
      pos       <= '0;
      step      <= '0;
      acc       <= '0;
      w2_ok     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_MUL && out_free) begin
        out_valid <= 1'b1;
        out_alpha <= hagm_pkg::div255(product);
        out_last  <= last_flag;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            alpha     <= s_tdata;
            last_flag <= is_last;
            if (n_zero) begin
              g          <= hagm_pkg::FULL_ALPHA;
              g_from_mem <= 1'b0;
              state      <= S_MUL;
            end else if (!in_seg) begin
              g_from_mem <= 1'b1;
              state      <= S_MUL;
            end else if (pos == '0) begin
              state <= w2_ok ? S_RD0 : S_DIVW;
            end else begin
              g          <= acc[15:8];
              g_from_mem <= 1'b0;
              acc        <= acc + step;
              state      <= S_MUL;
            end
            // Segment starts commit the row counters after the division.
            if (!(in_seg && pos == '0)) begin
              if (in_seg) begin
                pos <= seg_done ? '0 : pos_inc;
                if (seg_done) begin
                  seg <= seg + 1'b1;
                end
              end
              col <= col_inc;
              if (is_last) begin
                col  <= '0;
                seg  <= '0;
                pos  <= '0;
                step <= '0;
              end
            end
          end
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            w2    <= div_rsp.quotient[hagm_pkg::WIDTH_W-1:0];
            w2_ok <= 1'b1;
            state <= S_RD0;
          end
        end
        S_RD0: begin
          state <= S_RD1;
        end
        S_RD1: begin
          here  <= rd_byte;
          state <= S_RD2;
        end
        S_RD2: begin
          neg   <= rd_byte < here;
          state <= S_DIVS;
        end
        S_DIVS: begin
          if (div_rsp.done) begin
            g          <= here;
            g_from_mem <= 1'b0;
            step       <= step_val;
            acc        <= acc_here + step_val;
            pos        <= seg_done ? '0 : pos_inc;
            if (seg_done) begin
              seg <= seg + 1'b1;
            end
            col <= col_inc;
            if (is_last) begin
              col  <= '0;
              seg  <= '0;
              pos  <= '0;
              step <= '0;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // A register write restarts the row and the segment width.
      if (cfg.restart) begin
        col   <= '0;
        seg   <= '0;
        pos   <= '0;
        step  <= '0;
        w2_ok <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_alpha;
  assign m_tlast  = out_last;

endmodule
